FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

FILE: rtl/core/qba_pkg.sv
// ----------------------------------------------------------------------------
// Quantum budget accounting package
// Types, operation codes, register indexes and port widths of the block.
// ----------------------------------------------------------------------------
package qba_pkg;

    // Operation codes carried on the input tuser.
    localparam logic [2:0] FUNC_SET_REQ = 3'd0;
    localparam logic [2:0] FUNC_DEDUCT  = 3'd1;
    localparam logic [2:0] FUNC_CHECK   = 3'd2;
    localparam logic [2:0] FUNC_ADVANCE = 3'd3;
    localparam logic [2:0] FUNC_RELOAD  = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEADLINE_EN = 2'd0;
    localparam logic [1:0] CFG_IPC         = 2'd1;
    localparam logic [1:0] CFG_Q_RELOAD    = 2'd2;
    localparam logic [1:0] CFG_D_RELOAD    = 2'd3;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 47;
    localparam int IPC_W       = 16;
    localparam int RELOAD_W    = 47;
    localparam int REQ_W       = 32;
    localparam int CPU_W       = 2;
    localparam int FUNC_W      = 3;
    localparam int BUDGET_W    = 48;
    localparam int TARGET_W    = 48;
    localparam int TNOW_W      = 48;
    localparam int FLAG_W      = 2;
    // pending * 100 fits in 39 bits.
    localparam int DVD_W       = 39;

    localparam int S_TDATA_W   = 40;
    localparam int S_TUSER_W   = 3;
    localparam int RES_W       = 99;
    localparam int M_TDATA_W   = 104;

    localparam logic [IPC_W-1:0]    IPC_RST     = 16'd100;
    localparam logic [RELOAD_W-1:0] RELOAD_RST  = 47'd1000000;

    typedef struct packed {
        logic                deadline_en;
        logic [IPC_W-1:0]    ipc;
        logic [RELOAD_W-1:0] q_reload;
        logic [RELOAD_W-1:0] d_reload;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_UPD  = 4'b1000
    } t_state;

endpackage

FILE: rtl/core/qba_cfg.sv
// ----------------------------------------------------------------------------
// Quantum budget accounting configuration registers
// Holds the deadline enable, ipc and the two reload values.
// ----------------------------------------------------------------------------
module qba_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [qba_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [qba_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    output qba_pkg::t_cfg                        o_cfg
);

    qba_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadline_en <= 1'b0;
            r_cfg.ipc         <= qba_pkg::IPC_RST;
            r_cfg.q_reload    <= qba_pkg::RELOAD_RST;
            r_cfg.d_reload    <= qba_pkg::RELOAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qba_pkg::CFG_DEADLINE_EN: r_cfg.deadline_en <= i_cfg_wdata[0];
                qba_pkg::CFG_IPC:         r_cfg.ipc <= i_cfg_wdata[qba_pkg::IPC_W-1:0];
                qba_pkg::CFG_Q_RELOAD:    r_cfg.q_reload <= i_cfg_wdata;
                qba_pkg::CFG_D_RELOAD:    r_cfg.d_reload <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/qba_div.sv
// ----------------------------------------------------------------------------
// Quantum budget accounting divider
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module qba_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [qba_pkg::DVD_W-1:0]         i_dividend,
    input  logic [qba_pkg::IPC_W-1:0]         i_divisor,
    output logic [qba_pkg::DVD_W-1:0]         o_quotient,
    output qba_pkg::t_div_status              o_status
);

    localparam int CNT_W = $clog2(qba_pkg::DVD_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(qba_pkg::DVD_W - 1);

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    logic [qba_pkg::DVD_W-1:0] r_dvd;
    logic [qba_pkg::IPC_W-1:0] r_rem;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic [qba_pkg::IPC_W:0]   trial;
    logic [qba_pkg::IPC_W:0]   diff;
    logic                      ge;

    always_comb begin
        trial = {r_rem, r_dvd[qba_pkg::DVD_W-1]};
        ge    = trial >= {1'b0, i_divisor};
        diff  = trial - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[qba_pkg::DVD_W-2:0], ge};
            r_rem <= ge ? diff[qba_pkg::IPC_W-1:0] : trial[qba_pkg::IPC_W-1:0];
        end
    end

    assign o_quotient  = r_dvd;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

FILE: rtl/core/quantum_budget_accounting_unit.sv
// ----------------------------------------------------------------------------
// Quantum budget accounting unit
// Keeps per-CPU instruction budgets, deadline budgets, virtual time and
// depletion flags, and returns one result per operation. The block works on
// one transaction at a time. Set requirement, reload, unused codes, an
// out-of-range CPU and any operation whose ipc is zero go from the prepare
// step straight to the update step that loads the result register. Deduct,
// check and deduct and advance time pass through the prepare step, which
// starts the bit-serial divider on the dividend, then the divider, which forms
// pending*100/ipc one quotient bit per cycle, then its registered done flag,
// and then the update step. The input reopens in the cycle after the result
// register is loaded. A finished result waits in an output register, so the
// next transaction may be accepted before it is taken; that transaction then
// holds in its update step until the output register is free. Configuration
// must be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module quantum_budget_accounting_unit #(
    parameter int NUM_CPUS  = 4,
    parameter int TIME_BITS = 48
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [qba_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [qba_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: cpu [1:0], requirement [33:2], zero padding [39:34]
    input  logic [qba_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // tuser: func [2:0]
    input  logic [qba_pkg::S_TUSER_W-1:0]      s_axis_tuser,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: stop [0], flags [2:1], time_now [50:3], budget_left [98:51],
    // zero padding [103:99]
    output logic [qba_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    // Only four CPUs can be named by the two-bit index.
    localparam int DEPTH = (NUM_CPUS < 4) ? NUM_CPUS : 4;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (TIME_BITS > qba_pkg::DVD_W) ? TIME_BITS : qba_pkg::DVD_W;
    localparam int TW    = (TIME_BITS > qba_pkg::TNOW_W) ? TIME_BITS : qba_pkg::TNOW_W;

    localparam logic [qba_pkg::BUDGET_W-1:0] BUDGET_MIN =
        {1'b1, {(qba_pkg::BUDGET_W-1){1'b0}}};

    qba_pkg::t_cfg        cfg;
    qba_pkg::t_div_status div_st;
    logic [qba_pkg::DVD_W-1:0] quot;

    qba_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Per-CPU accounting state.
    logic [qba_pkg::REQ_W-1:0]    r_pend [DEPTH];
    logic [qba_pkg::BUDGET_W-1:0] r_qnt  [DEPTH];
    logic [qba_pkg::BUDGET_W-1:0] r_ddl  [DEPTH];
    logic [TIME_BITS-1:0]         r_vt   [DEPTH];
    logic [qba_pkg::FLAG_W-1:0]   r_flg  [DEPTH];
    logic [qba_pkg::TARGET_W-1:0] r_tgt  [DEPTH];

    qba_pkg::t_state r_state, n_state;

    logic [qba_pkg::FUNC_W-1:0] r_func;
    logic [qba_pkg::CPU_W-1:0]  r_cpu;
    logic [qba_pkg::REQ_W-1:0]  r_req;

    logic                       r_out_valid;
    logic [qba_pkg::RES_W-1:0]  r_out_data;

    logic [IW-1:0]              idx;
    logic                       cpu_ok;
    logic                       ipc_ok;
    logic                       s_acc;
    logic                       need_div;
    logic                       div_start;
    logic                       upd_fire;
    logic [qba_pkg::DVD_W-1:0]  dividend;
    logic [qba_pkg::DVD_W-1:0]  pend_x;

    logic [qba_pkg::REQ_W-1:0]    cur_p,   n_p;
    logic [qba_pkg::BUDGET_W-1:0] cur_q,   n_q;
    logic [qba_pkg::BUDGET_W-1:0] cur_d,   n_d;
    logic [TIME_BITS-1:0]         cur_vt,  n_vt, vt_adv;
    logic [qba_pkg::FLAG_W-1:0]   cur_fl,  n_fl;
    logic [qba_pkg::TARGET_W-1:0] cur_tg,  n_tg;
    logic [SW-1:0]                vt_sum;
    logic [TW-1:0]                vt_wide;
    logic                         stop;
    logic [qba_pkg::RES_W-1:0]    res;

    // Budget minus pending count, held at the most negative budget.
    function automatic logic [qba_pkg::BUDGET_W-1:0] sat_sub(
        input logic [qba_pkg::BUDGET_W-1:0] b,
        input logic [qba_pkg::REQ_W-1:0]    p
    );
        logic [qba_pkg::BUDGET_W:0] r;
        r = {b[qba_pkg::BUDGET_W-1], b} - (qba_pkg::BUDGET_W+1)'(p);
        if (r[qba_pkg::BUDGET_W] && !r[qba_pkg::BUDGET_W-1]) begin
            sat_sub = BUDGET_MIN;
        end else begin
            sat_sub = r[qba_pkg::BUDGET_W-1:0];
        end
    endfunction

    assign idx    = r_cpu[IW-1:0];
    assign cpu_ok = 32'(r_cpu) < NUM_CPUS;
    assign ipc_ok = cfg.ipc != '0;
    assign s_acc  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = r_state == qba_pkg::ST_IDLE;

    assign need_div = cpu_ok && ipc_ok &&
                      (r_func == qba_pkg::FUNC_DEDUCT || r_func == qba_pkg::FUNC_CHECK ||
                       r_func == qba_pkg::FUNC_ADVANCE);
    assign div_start = (r_state == qba_pkg::ST_PREP) && need_div;
    assign upd_fire  = (r_state == qba_pkg::ST_UPD) && (!r_out_valid || m_axis_tready);

    // pending * 100 as (p << 6) + (p << 5) + (p << 2).
    assign pend_x   = qba_pkg::DVD_W'(r_pend[idx]);
    assign dividend = (pend_x << 6) + (pend_x << 5) + (pend_x << 2);

    qba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (cfg.ipc),
        .o_quotient (quot),
        .o_status   (div_st)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            qba_pkg::ST_IDLE: if (s_acc) n_state = qba_pkg::ST_PREP;
            qba_pkg::ST_PREP: n_state = need_div ? qba_pkg::ST_DIV : qba_pkg::ST_UPD;
            qba_pkg::ST_DIV:  if (div_st.done) n_state = qba_pkg::ST_UPD;
            qba_pkg::ST_UPD:  if (upd_fire) n_state = qba_pkg::ST_IDLE;
            default:          n_state = qba_pkg::ST_IDLE;
        endcase
    end

    // Next values of the addressed entry.
    always_comb begin
        cur_p  = r_pend[idx];
        cur_q  = r_qnt[idx];
        cur_d  = r_ddl[idx];
        cur_vt = r_vt[idx];
        cur_fl = r_flg[idx];
        cur_tg = r_tgt[idx];

        vt_sum = SW'(cur_vt) + SW'(quot);
        vt_adv = ipc_ok ? vt_sum[TIME_BITS-1:0] : cur_vt;

        n_p  = cur_p;
        n_q  = cur_q;
        n_d  = cur_d;
        n_vt = cur_vt;
        n_fl = cur_fl;
        n_tg = cur_tg;
        stop = 1'b0;

        case (r_func)
            qba_pkg::FUNC_SET_REQ: begin
                n_p = r_req;
            end
            qba_pkg::FUNC_DEDUCT: begin
                n_q = sat_sub(cur_q, cur_p);
                if (cfg.deadline_en) n_d = sat_sub(cur_d, cur_p);
                n_vt = vt_adv;
                n_p  = '0;
            end
            qba_pkg::FUNC_CHECK: begin
                if (ipc_ok) begin
                    n_tg = cur_tg + qba_pkg::TARGET_W'(cur_p);
                    n_q  = sat_sub(cur_q, cur_p);
                    if (cfg.deadline_en) n_d = sat_sub(cur_d, cur_p);
                    n_vt = vt_adv;
                    n_p  = '0;
                    if (n_q[qba_pkg::BUDGET_W-1] || n_q == '0) n_fl[0] = 1'b1;
                    if (cfg.deadline_en && (n_d[qba_pkg::BUDGET_W-1] || n_d == '0)) begin
                        n_fl[1] = 1'b1;
                    end
                    stop = n_fl != '0;
                end
            end
            qba_pkg::FUNC_ADVANCE: begin
                n_vt = vt_adv;
                n_p  = '0;
            end
            qba_pkg::FUNC_RELOAD: begin
                n_q  = {1'b0, cfg.q_reload};
                n_d  = {1'b0, cfg.d_reload};
                n_fl = '0;
            end
            default: ;
        endcase

        vt_wide = TW'(n_vt);
        res = cpu_ok ? {n_q, vt_wide[qba_pkg::TNOW_W-1:0], n_fl, stop} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qba_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                r_pend[i] <= '0;
                r_qnt[i]  <= '0;
                r_ddl[i]  <= '0;
                r_vt[i]   <= '0;
                r_flg[i]  <= '0;
                r_tgt[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (upd_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (upd_fire && cpu_ok) begin
                r_pend[idx] <= n_p;
                r_qnt[idx]  <= n_q;
                r_ddl[idx]  <= n_d;
                r_vt[idx]   <= n_vt;
                r_flg[idx]  <= n_fl;
                r_tgt[idx]  <= n_tg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_func <= s_axis_tuser;
            r_cpu  <= s_axis_tdata[qba_pkg::CPU_W-1:0];
            r_req  <= s_axis_tdata[qba_pkg::CPU_W +: qba_pkg::REQ_W];
        end
        if (upd_fire) begin
            r_out_data <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(qba_pkg::M_TDATA_W-qba_pkg::RES_W)'(0), r_out_data};

endmodule

FILE: rtl/core/qba_checker.sv
// ----------------------------------------------------------------------------
// Quantum budget accounting checker
// Port-level assertions on the result stream and the input handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qba_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [qba_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    // A stalled result holds its valid and its data.
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

    // One transaction at a time: the input closes right after an acceptance.
    `ASSERT_CLK_RST(a_one_at_a_time, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)

    // Stop is only reported together with a set depletion flag.
    `ASSERT_CLK_RST(a_stop_flags, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[2:1] != 2'b00))

    // Reset empties the result register.
    `ASSERT_CLK(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind quantum_budget_accounting_unit qba_checker u_qba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
